// ----- rtl/oepd_pkg.sv -----
// Shared types, codes and character helpers for the execute-payload decoder.
package oepd_pkg;

   localparam int PENDING_DEPTH_DEF = 32;

   // Result status codes
   localparam logic [1:0] ST_DATA     = 2'd0;
   localparam logic [1:0] ST_END      = 2'd1;
   localparam logic [1:0] ST_NONE     = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // Characters of interest
   localparam logic [7:0] CH_E      = 8'h45;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;

   // Source of the next output transfer
   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_HEAD,
      OUT_PEND,
      OUT_END
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        pop;
      logic        push;
      logic        set_ovf;
      logic        set_seen;
      logic        prime;
      logic        adv;
      logic        clr_count;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic q_empty;
      logic q_one;
      logic head_space;
      logic seen;
      logic cnt_zero;
      logic cnt_full;
      logic flush_last;
      logic end_pend;
      logic out_free;
   } dp_status_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   // Letters: low nibble of 'a'/'A' is 1, so add 9.
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      if (c <= 8'h39) begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

endpackage

// ----- rtl/oepd_ctrl.sv -----
// Sequencer: walks the decoded-byte queue, whitespace release and end result.
module oepd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  oepd_pkg::dp_status_type status,
   output oepd_pkg::dp_cmd_type    cmd
);
   import oepd_pkg::*;

   typedef enum logic [1:0] {
      S_RUN,
      S_PRIME,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      head_done;
   logic      accept_ok;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      head_done = 1'b0;
      case (state_ff)
         S_RUN: begin
            if (!status.q_empty) begin
               if (status.head_space) begin
                  if (status.seen) begin
                     if (status.cnt_full) begin
                        cmd.set_ovf = 1'b1;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  cmd.pop   = 1'b1;
                  head_done = 1'b1;
               end else if (!status.cnt_zero) begin
                  state_in = S_PRIME;
               end else if (status.out_free) begin
                  cmd.out_sel  = OUT_HEAD;
                  cmd.set_seen = 1'b1;
                  cmd.pop      = 1'b1;
                  head_done    = 1'b1;
               end
            end else if (status.end_pend && status.out_free) begin
               cmd.out_sel = OUT_END;
            end
         end
         S_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = S_FLUSH;
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.out_sel = OUT_PEND;
               cmd.adv     = 1'b1;
               if (status.flush_last) begin
                  cmd.clr_count = 1'b1;
                  state_in      = S_RUN;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
      accept_ok = (state_ff == S_RUN) && !status.end_pend &&
                  (status.q_empty || (status.q_one && head_done));
      cmd.load  = req_valid && accept_ok;
   end

   assign req_stall = !accept_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/oepd_datapath.sv -----
// Datapath: prefix/escape decode, decoded-byte queue, whitespace buffer, output register.
module oepd_datapath #(
   parameter int PENDING_DEPTH = oepd_pkg::PENDING_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_in_last,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_out_status,
   output logic                  rsp_out_last,
   input  oepd_pkg::dp_cmd_type    cmd,
   output oepd_pkg::dp_status_type status
);
   import oepd_pkg::*;

   localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_PREFIX_E,
      PH_PREFIX_SEMI,
      PH_BODY,
      PH_REJECT
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_SLASH,
      ESC_X,
      ESC_X_DIGIT
   } esc_type;

   phase_type        phase_ff;
   phase_type        ph_in;
   esc_type          esc_ff;
   esc_type          esc_in;
   logic [7:0]       held_ff;
   logic [7:0]       held_in;
   logic             seen_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data_ff;
   logic [7:0]       pend_mem [PENDING_DEPTH];

   logic [7:0]       q_ff [4];
   logic [2:0]       qn_ff;
   logic [7:0]       dq [4];
   logic [2:0]       dn;
   logic             plain;
   logic             end_pend_ff;
   logic             end_body_ff;

   logic             out_v_ff;
   logic [7:0]       out_byte_ff;
   logic [1:0]       out_status_ff;
   logic             out_last_ff;
   logic [1:0]       end_status;

   // Decode of one raw byte into up to four decoded bytes.
   always_comb begin
      ph_in   = phase_ff;
      esc_in  = esc_ff;
      held_in = held_ff;
      dq      = '{default: 8'h00};
      dn      = 3'd0;
      plain   = 1'b0;
      case (phase_ff)
         PH_PREFIX_E: begin
            ph_in = (req_in_byte == CH_E) ? PH_PREFIX_SEMI : PH_REJECT;
         end
         PH_PREFIX_SEMI: begin
            ph_in = (req_in_byte == CH_SEMI) ? PH_BODY : PH_REJECT;
         end
         PH_BODY: begin
            case (esc_ff)
               ESC_NONE: begin
                  plain = 1'b1;
               end
               ESC_SLASH: begin
                  esc_in = ESC_NONE;
                  if (req_in_byte == CH_BSLASH) begin
                     dq[dn[1:0]] = CH_BSLASH;
                     dn          = dn + 3'd1;
                  end else if (req_in_byte == CH_X) begin
                     esc_in = ESC_X;
                  end else begin
                     dq[dn[1:0]] = CH_BSLASH;
                     dn          = dn + 3'd1;
                     plain       = 1'b1;
                  end
               end
               ESC_X: begin
                  if (is_hex(req_in_byte)) begin
                     held_in = req_in_byte;
                     esc_in  = ESC_X_DIGIT;
                  end else begin
                     esc_in      = ESC_NONE;
                     dq[dn[1:0]] = CH_BSLASH;
                     dn          = dn + 3'd1;
                     dq[dn[1:0]] = CH_X;
                     dn          = dn + 3'd1;
                     plain       = 1'b1;
                  end
               end
               ESC_X_DIGIT: begin
                  esc_in = ESC_NONE;
                  if (is_hex(req_in_byte)) begin
                     dq[dn[1:0]] = {hex_val(held_ff), hex_val(req_in_byte)};
                     dn          = dn + 3'd1;
                  end else begin
                     dq[dn[1:0]] = CH_BSLASH;
                     dn          = dn + 3'd1;
                     dq[dn[1:0]] = CH_X;
                     dn          = dn + 3'd1;
                     dq[dn[1:0]] = held_ff;
                     dn          = dn + 3'd1;
                     plain       = 1'b1;
                  end
               end
               default: begin
                  plain = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase
      if (plain) begin
         if (req_in_byte == CH_BSLASH) begin
            esc_in = ESC_SLASH;
         end else begin
            dq[dn[1:0]] = req_in_byte;
            dn          = dn + 3'd1;
         end
      end
      // cut-off escape passes through as text
      if (req_in_last && ph_in == PH_BODY) begin
         if (esc_in != ESC_NONE) begin
            dq[dn[1:0]] = CH_BSLASH;
            dn          = dn + 3'd1;
         end
         if (esc_in == ESC_X || esc_in == ESC_X_DIGIT) begin
            dq[dn[1:0]] = CH_X;
            dn          = dn + 3'd1;
         end
         if (esc_in == ESC_X_DIGIT) begin
            dq[dn[1:0]] = held_in;
            dn          = dn + 3'd1;
         end
      end
   end

   assign end_status = (end_body_ff && seen_ff) ? (ovf_ff ? ST_OVERFLOW : ST_END) : ST_NONE;

   always_comb begin
      if (cmd.prime) begin
         rd_addr = '0;
      end else if (cmd.adv) begin
         rd_addr = IDX_W'(idx_ff + 1'b1);
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_comb begin
      status            = '0;
      status.q_empty    = (qn_ff == 3'd0);
      status.q_one      = (qn_ff == 3'd1);
      status.head_space = is_space(q_ff[0]);
      status.seen       = seen_ff;
      status.cnt_zero   = (count_ff == '0);
      status.cnt_full   = (count_ff == CNT_W'(PENDING_DEPTH));
      status.flush_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      status.end_pend   = end_pend_ff;
      status.out_free   = !out_v_ff || !rsp_stall;
   end

   // Whitespace buffer
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pend_mem[count_ff[IDX_W-1:0]] <= q_ff[0];
      end
      rd_data_ff <= pend_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PREFIX_E;
         esc_ff      <= ESC_NONE;
         held_ff     <= 8'h00;
         seen_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         count_ff    <= '0;
         idx_ff      <= '0;
         qn_ff       <= 3'd0;
         end_pend_ff <= 1'b0;
         end_body_ff <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         // a load only comes when the queue is empty or with its retiring last entry, so it replaces the queue
         if (cmd.load) begin
            phase_ff    <= ph_in;
            esc_ff      <= esc_in;
            held_ff     <= held_in;
            q_ff        <= dq;
            qn_ff       <= dn;
            end_pend_ff <= req_in_last;
            end_body_ff <= (ph_in == PH_BODY);
         end else if (cmd.pop) begin
            q_ff[0] <= q_ff[1];
            q_ff[1] <= q_ff[2];
            q_ff[2] <= q_ff[3];
            qn_ff   <= qn_ff - 3'd1;
         end
         if (cmd.push) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.set_seen) begin
            seen_ff <= 1'b1;
         end
         if (cmd.prime) begin
            idx_ff <= '0;
         end else if (cmd.adv) begin
            idx_ff <= IDX_W'(idx_ff + 1'b1);
         end
         if (cmd.clr_count) begin
            count_ff <= '0;
         end
         if (cmd.out_sel == OUT_END) begin
            phase_ff    <= PH_PREFIX_E;
            esc_ff      <= ESC_NONE;
            held_ff     <= 8'h00;
            seen_ff     <= 1'b0;
            ovf_ff      <= 1'b0;
            count_ff    <= '0;
            end_pend_ff <= 1'b0;
         end
         if (cmd.out_sel != OUT_NONE) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      case (cmd.out_sel)
         OUT_HEAD: begin
            out_byte_ff   <= q_ff[0];
            out_status_ff <= ST_DATA;
            out_last_ff   <= 1'b0;
         end
         OUT_PEND: begin
            out_byte_ff   <= rd_data_ff;
            out_status_ff <= ST_DATA;
            out_last_ff   <= 1'b0;
         end
         OUT_END: begin
            out_byte_ff   <= 8'h00;
            out_status_ff <= end_status;
            out_last_ff   <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_out_status = out_status_ff;
   assign rsp_out_last   = out_last_ff;

endmodule

// ----- rtl/osc_execute_payload_decoder.sv -----
// Result path: a decoded byte is registered in the queue, then in the output register.
// Throughput: one byte per cycle when it decodes to at most one byte and the output
//   is not stalled; each further decoded byte retires before the next is taken; held
//   whitespace is released (spot, prime buffer read port, send each), then the end result.
// Reset: synchronous, active high; clears control state and counts, the whitespace
//   buffer itself is not cleared (no entry is read before it is written).
module osc_execute_payload_decoder #(
   parameter int PENDING_DEPTH = oepd_pkg::PENDING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_status,
   output logic       rsp_out_last
);
   import oepd_pkg::*;

   // Controller/datapath split:
   //  - the datapath decodes each taken byte (prefix check, escapes) into a
   //    queue of up to four decoded bytes;
   //  - the controller drains that queue one entry per cycle when not stalled,
   //    dropping leading whitespace, routing later whitespace into the pending
   //    buffer and releasing it ahead of the next non-space byte, then issues the end result.
   // A new byte is taken once the queue is empty or its last entry retires, outside a flush and with no end pending.

   dp_cmd_type    cmd;
   dp_status_type status;

   oepd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   oepd_datapath #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_status (rsp_out_status),
      .rsp_out_last   (rsp_out_last),
      .cmd            (cmd),
      .status         (status)
   );

`ifndef NO_ASSERTIONS
   // After the final byte of a payload, input holds off until the end result is out.
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_in_last) |=> req_stall)
      else $error("byte taken right after payload end");

   // Only data results go out without the last mark.
   a_data_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_last) |-> (rsp_out_status == ST_DATA))
      else $error("non-data status on a data result");

   // End result carries a zero byte and never a data status.
   a_end_fmt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_last) |-> (rsp_out_byte == 8'h00 && rsp_out_status != ST_DATA))
      else $error("malformed end result");

   // End result only after every decoded byte is retired.
   a_end_after_queue: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sel == OUT_END) |-> status.q_empty)
      else $error("end result with decoded bytes outstanding");
`endif

endmodule
